>>> hdl/cte_pkg.sv
// Shared types and constants for the credential table engine.
// No dependencies.
package cte_pkg;

  localparam logic [1:0] OP_VERIFY = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_AUTH_FAIL = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_DUP       = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  localparam logic [63:0] HASH_SEED = 64'd5381;

  // token that walks the cell chain
  typedef struct packed {
    logic        found;
    logic        hash_ok;
    logic        empty;
    logic [15:0] uid;
  } cte_tok_t;

  // request broadcast to every cell
  typedef struct packed {
    logic [1:0]  op;
    logic        commit;
    logic [63:0] name;
    logic [63:0] hash;
    logic [15:0] uid;
  } cte_req_t;

endpackage

>>> hdl/cte_cell.sv
// One table entry of the credential table chain plus its token stage.
// Depends on cte_pkg.
module cte_cell import cte_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cte_req_t req,
  input  logic     tok_in_valid,
  input  cte_tok_t tok_in,
  output logic     tok_out_valid,
  output cte_tok_t tok_out
);

  logic        ent_valid;
  logic [63:0] ent_name;
  logic [63:0] ent_hash;
  logic [15:0] ent_uid;
  logic        match;
  logic        first;
  logic        claim;
  cte_tok_t    tok_next;

  assign match = ent_valid && (ent_name == req.name);
  assign first = !tok_in.found && match;
  assign claim = !tok_in.found && !ent_valid;

  always_comb begin
    tok_next = tok_in;
    if (req.commit) begin
      tok_next.found = tok_in.found | !ent_valid;
    end else begin
      tok_next.found = tok_in.found | match;
      tok_next.empty = tok_in.empty | !ent_valid;
      if (first) begin
        tok_next.hash_ok = (ent_hash == req.hash);
        tok_next.uid     = ent_uid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid     <= 1'b0;
      tok_out_valid <= 1'b0;
    end else begin
      tok_out_valid <= tok_in_valid;
      if (tok_in_valid) begin
        if (req.commit) begin
          if (claim) begin
            ent_valid <= 1'b1;
          end
        end else if (req.op == OP_DELETE && first) begin
          ent_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    tok_out <= tok_next;
    if (tok_in_valid && req.commit && claim) begin
      ent_name <= req.name;
      ent_hash <= req.hash;
      ent_uid  <= req.uid;
    end
  end

endmodule

>>> hdl/credential_table_engine.sv
// Credential table engine: a nonzero password byte folds into the hash each cycle (1 item/cycle).
// A last item scans the chain of MAX_USERS cells; an add that stores takes a second pass.
// Input stalls from then until the result has been registered at the output.
// Sync reset clears all entry valid flags at once and reloads the hash seed 5381.
// Depends on cte_pkg and cte_cell.
module credential_table_engine import cte_pkg::*; #(
  parameter int MAX_USERS  = 16,
  parameter int NAME_CHARS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [63:0] user_name,
  input  logic [7:0]  password_char,
  input  logic        last,
  input  logic [15:0] new_uid,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [15:0] user_id
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;
  localparam logic [1:0] S_DONE   = 2'd3;

  logic [1:0]  state;
  logic [63:0] acc;
  logic [63:0] acc_next;
  logic [63:0] clean_name;
  logic        alive;
  logic        start;
  cte_req_t    req;
  logic [2:0]  res_status;
  logic [15:0] res_uid;

  logic     tok_v [0:MAX_USERS];
  cte_tok_t tok   [0:MAX_USERS];

  assign in_stall = (state != S_IDLE);

  assign acc_next = (password_char == 8'd0) ? acc
                  : (acc << 5) + acc + {56'd0, password_char};

  always_comb begin
    alive      = 1'b1;
    clean_name = '0;
    for (int i = 0; i < NAME_CHARS; i++) begin
      if (user_name[8*i +: 8] == 8'd0) begin
        alive = 1'b0;
      end
      if (alive) begin
        clean_name[8*i +: 8] = user_name[8*i +: 8];
      end
    end
  end

  assign tok_v[0] = start;
  assign tok[0]   = '0;

  for (genvar g = 0; g < MAX_USERS; g++) begin : g_cell
    cte_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .req          (req),
      .tok_in_valid (tok_v[g]),
      .tok_in       (tok[g]),
      .tok_out_valid(tok_v[g+1]),
      .tok_out      (tok[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      start     <= 1'b0;
      out_valid <= 1'b0;
      acc       <= HASH_SEED;
    end else begin
      start <= 1'b0;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (last) begin
              req.op     <= operation;
              req.commit <= 1'b0;
              req.name   <= clean_name;
              req.hash   <= acc_next;
              req.uid    <= new_uid;
              acc        <= HASH_SEED;
              start      <= 1'b1;
              state      <= S_SCAN;
            end else begin
              acc <= acc_next;
            end
          end
        end
        S_SCAN: begin
          if (tok_v[MAX_USERS]) begin
            state   <= S_DONE;
            res_uid <= 16'd0;
            case (req.op)
              OP_VERIFY: begin
                if (tok[MAX_USERS].found && tok[MAX_USERS].hash_ok) begin
                  res_status <= ST_OK;
                  res_uid    <= tok[MAX_USERS].uid;
                end else begin
                  res_status <= ST_AUTH_FAIL;
                end
              end
              OP_ADD: begin
                if (!tok[MAX_USERS].empty) begin
                  res_status <= ST_FULL;
                end else if (tok[MAX_USERS].found) begin
                  res_status <= ST_DUP;
                end else begin
                  req.commit <= 1'b1;
                  start      <= 1'b1;
                  state      <= S_COMMIT;
                end
              end
              OP_DELETE: begin
                res_status <= tok[MAX_USERS].found ? ST_OK : ST_NOT_FOUND;
              end
              default: begin
                res_status <= ST_NOT_FOUND;
              end
            endcase
          end
        end
        S_COMMIT: begin
          if (tok_v[MAX_USERS]) begin
            res_status <= ST_OK;
            res_uid    <= 16'd0;
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            status    <= res_status;
            user_id   <= res_uid;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hdl/cte_checker.sv
// Port-level checks for credential_table_engine, bound to the top level.
// Depends on cte_pkg.
module cte_checker import cte_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        last,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  status,
  input logic [15:0] user_id
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(user_id))
    else $error("result changed while stalled");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_NOT_FOUND)
    else $error("status code out of range");

  a_uid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> user_id == 16'd0)
    else $error("user id nonzero on failed request");

  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && last |=> in_stall)
    else $error("input not stalled during table scan");

endmodule

bind credential_table_engine cte_checker u_cte_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .last     (last),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .status   (status),
  .user_id  (user_id)
);
